>>> design/assert_macros.svh
// Assertion macros shared by the display timeout controller RTL.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DTA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dta assertion failed");
`define DTA_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("dta forbidden condition seen");
`else
`define DTA_ASSERT(lbl, clk, rst_n, prop)
`define DTA_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> design/dta_pkg.sv
// Package for the display timeout controller: types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dta_pkg;

    localparam logic [31:0] SAMPLE_PERIOD_MS = 32'd50;
    localparam logic [31:0] SETTLE_MS        = 32'd5000;
    localparam logic [31:0] MS_PER_S         = 32'd1000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_BRIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPORTS_EN   = 3'd3;

    localparam logic [15:0] RST_INIT_TIMEOUT = 16'd30;
    localparam logic [15:0] RST_MAX_TIMEOUT  = 16'd3600;
    localparam logic [15:0] RST_INIT_BRIGHT  = 16'd0;
    localparam logic [31:0] RST_OFF_DELAY    = 32'd30000;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_TIMEOUT = 2'd1;
    localparam logic [1:0] MODE_BRIGHT  = 2'd2;

    localparam logic [2:0] KIND_T_VAL = 3'd0;
    localparam logic [2:0] KIND_T_END = 3'd1;
    localparam logic [2:0] KIND_B_VAL = 3'd2;
    localparam logic [2:0] KIND_B_END = 3'd3;
    localparam logic [2:0] KIND_OFF   = 3'd4;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] timeout_knob_pos;
        logic [15:0] brightness_knob_pos;
        logic        new_event;
    } t_item;

    typedef struct packed {
        logic [15:0] report_value;
        logic [2:0]  report_kind;
        logic        last_of_run;
    } t_result;

    // Up to two results per item; slot 1 is only used when slot 0 is.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_push;

    typedef struct packed {
        logic        load;
        logic [15:0] timeout_ref;
        logic [15:0] bright_ref;
        logic [31:0] off_delay;
    } t_cfg_load;

    function automatic logic [31:0] ms_of_s(input logic [15:0] secs);
        logic [31:0] prod;
        prod = {16'd0, secs} * MS_PER_S;
        return prod;
    endfunction

endpackage

`default_nettype wire

>>> design/dta_cfg.sv
// Configuration registers of the display timeout controller.
// Produces the setup reload that follows a write to a timeout or brightness register; depends on dta_pkg.
`default_nettype none

module dta_cfg import dta_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg_load                  o_load,
    output logic                       o_rep_en
);

    logic [15:0] r_init, n_init;
    logic [15:0] r_max, n_max;
    logic [15:0] r_bright, n_bright;
    logic        r_rep_en, n_rep_en;
    logic [15:0] want_s;

    always_comb begin
        n_init      = r_init;
        n_max       = r_max;
        n_bright    = r_bright;
        n_rep_en    = r_rep_en;
        o_load.load = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INIT_TIMEOUT: begin
                    n_init      = i_cfg_data;
                    o_load.load = 1'b1;
                end
                REG_MAX_TIMEOUT: begin
                    n_max       = i_cfg_data;
                    o_load.load = 1'b1;
                end
                REG_INIT_BRIGHT: begin
                    n_bright    = i_cfg_data;
                    o_load.load = 1'b1;
                end
                REG_REPORTS_EN: begin
                    n_rep_en = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
        // Both delays fit in 32 bits, so clamping in seconds matches clamping in ms.
        want_s             = (n_init > n_max) ? n_max : n_init;
        o_load.off_delay   = ms_of_s(want_s);
        o_load.timeout_ref = n_init;
        o_load.bright_ref  = n_bright;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= RST_INIT_TIMEOUT;
            r_max    <= RST_MAX_TIMEOUT;
            r_bright <= RST_INIT_BRIGHT;
            r_rep_en <= 1'b1;
        end else begin
            r_init   <= n_init;
            r_max    <= n_max;
            r_bright <= n_bright;
            r_rep_en <= n_rep_en;
        end
    end

    assign o_rep_en = r_rep_en;

endmodule

`default_nettype wire

>>> design/dta_core.sv
// Per-item state update of the display timeout controller.
// Holds the timer, mode and knob references; depends on dta_pkg.
`default_nettype none
`include "assert_macros.svh"

module dta_core import dta_pkg::*; #(
    parameter logic [31:0] SAMPLE_MS       = SAMPLE_PERIOD_MS,
    parameter logic [31:0] SETTLE_LIMIT_MS = SETTLE_MS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_item     i_item,
    input  wire t_cfg_load i_cfg_load,
    input  wire logic      i_rep_en,
    output t_push          o_push
);

    logic [31:0] r_last_stamp, n_last_stamp;
    logic [31:0] r_elapsed, n_elapsed;
    logic [1:0]  r_mode, n_mode;
    logic [15:0] r_tref, n_tref;
    logic [15:0] r_bref, n_bref;
    logic [31:0] r_off_delay, n_off_delay;
    logic        r_display_on, n_display_on;
    logic        r_pending, n_pending;

    logic [31:0] delta;
    logic        early;
    logic        wake;
    logic [32:0] sum_wide;
    logic [31:0] sat_sum;
    logic        t_move;
    logic        b_move;
    logic [31:0] el_mid;
    logic        have_a;
    logic        have_b;
    t_result     res_a;
    t_result     res_b;
    logic        take_wake;
    logic        wake_done;
    logic        early_hold;
    logic [65:0] hold_bits;

    assign delta    = i_item.now_ms - r_last_stamp;
    assign early    = delta < SAMPLE_MS;
    assign wake     = r_pending | i_item.new_event;
    assign sum_wide = {1'b0, r_elapsed} + {1'b0, delta};
    assign sat_sum  = sum_wide[32] ? '1 : sum_wide[31:0];
    assign t_move   = i_item.timeout_knob_pos != r_tref;
    assign b_move   = i_item.brightness_knob_pos != r_bref;
    assign take_wake = i_fire && !early && wake && !i_cfg_load.load;
    assign wake_done = r_display_on && !r_pending && r_mode == MODE_IDLE && r_elapsed == '0;
    assign early_hold = i_fire && early && !i_cfg_load.load;
    assign hold_bits  = {r_last_stamp, r_elapsed, r_mode};

    always_comb begin
        n_last_stamp = r_last_stamp;
        n_elapsed    = r_elapsed;
        n_mode       = r_mode;
        n_tref       = r_tref;
        n_bref       = r_bref;
        n_off_delay  = r_off_delay;
        n_display_on = r_display_on;
        n_pending    = r_pending;
        el_mid       = sat_sum;
        have_a       = 1'b0;
        have_b       = 1'b0;
        res_a        = '0;
        res_b        = '0;

        if (i_cfg_load.load) begin
            n_tref      = i_cfg_load.timeout_ref;
            n_bref      = i_cfg_load.bright_ref;
            n_off_delay = i_cfg_load.off_delay;
            n_mode      = MODE_IDLE;
        end else if (i_fire) begin
            if (early) begin
                // Too soon: only a wake request is remembered for later.
                n_pending = wake;
            end else begin
                n_last_stamp = i_item.now_ms;
                n_pending    = 1'b0;
                unique case (r_mode)
                    MODE_TIMEOUT: begin
                        if (t_move) begin
                            n_tref             = i_item.timeout_knob_pos;
                            el_mid             = '0;
                            have_a             = 1'b1;
                            res_a.report_value = i_item.timeout_knob_pos;
                            res_a.report_kind  = KIND_T_VAL;
                        end
                        n_elapsed = el_mid;
                        if (el_mid > SETTLE_LIMIT_MS || wake) begin
                            n_mode             = MODE_IDLE;
                            n_elapsed          = '0;
                            n_off_delay        = ms_of_s(i_item.timeout_knob_pos);
                            have_b             = 1'b1;
                            res_b.report_value = i_item.timeout_knob_pos;
                            res_b.report_kind  = KIND_T_END;
                        end
                    end
                    MODE_BRIGHT: begin
                        if (b_move) begin
                            n_bref             = i_item.brightness_knob_pos;
                            el_mid             = '0;
                            have_a             = 1'b1;
                            res_a.report_value = i_item.brightness_knob_pos;
                            res_a.report_kind  = KIND_B_VAL;
                        end
                        n_elapsed = el_mid;
                        if (el_mid > SETTLE_LIMIT_MS || wake) begin
                            n_mode             = MODE_IDLE;
                            n_elapsed          = '0;
                            have_b             = 1'b1;
                            res_b.report_value = i_item.brightness_knob_pos;
                            res_b.report_kind  = KIND_B_END;
                        end
                    end
                    default: begin
                        if (t_move) begin
                            n_mode = MODE_TIMEOUT;
                            n_tref = i_item.timeout_knob_pos;
                            el_mid = '0;
                        end else if (b_move) begin
                            n_mode = MODE_BRIGHT;
                            n_bref = i_item.brightness_knob_pos;
                            el_mid = '0;
                        end
                        n_elapsed = el_mid;
                        if (el_mid > r_off_delay && r_display_on) begin
                            // Park the timer just past the delay so it stays expired.
                            n_display_on       = 1'b0;
                            n_elapsed          = r_off_delay + SAMPLE_MS;
                            have_b             = 1'b1;
                            res_b.report_value = '0;
                            res_b.report_kind  = KIND_OFF;
                        end
                    end
                endcase
                if (wake) begin
                    n_elapsed    = '0;
                    n_display_on = 1'b1;
                    n_mode       = MODE_IDLE;
                end
            end
        end

        res_a.last_of_run = !have_b;
        res_b.last_of_run = 1'b1;
        o_push.valid0 = i_rep_en && (have_a || have_b);
        o_push.valid1 = i_rep_en && have_a && have_b;
        o_push.res0   = have_a ? res_a : res_b;
        o_push.res1   = res_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp <= '0;
            r_elapsed    <= '0;
            r_mode       <= MODE_IDLE;
            r_tref       <= RST_INIT_TIMEOUT;
            r_bref       <= RST_INIT_BRIGHT;
            r_off_delay  <= RST_OFF_DELAY;
            r_display_on <= 1'b1;
            r_pending    <= 1'b0;
        end else begin
            r_last_stamp <= n_last_stamp;
            r_elapsed    <= n_elapsed;
            r_mode       <= n_mode;
            r_tref       <= n_tref;
            r_bref       <= n_bref;
            r_off_delay  <= n_off_delay;
            r_display_on <= n_display_on;
            r_pending    <= n_pending;
        end
    end

    `DTA_ASSERT(a_wake_served, i_clk, i_rst_n, take_wake |=> wake_done)
    `DTA_ASSERT(a_early_hold, i_clk, i_rst_n, early_hold |=> $stable(hold_bits))
    `DTA_NEVER(a_quiet, i_clk, i_rst_n, !i_rep_en && o_push.valid0)
    `DTA_NEVER(a_slot_order, i_clk, i_rst_n, o_push.valid1 && !o_push.valid0)

endmodule

`default_nettype wire

>>> design/dta_rqueue.sv
// Result queue of the display timeout controller: takes up to two results
// a cycle and hands out one while the output is not stalled. Depends on dta_pkg.
`default_nettype none
`include "assert_macros.svh"

module dta_rqueue import dta_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_result    o_head
);

    t_result            r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]   r_wp;
    logic [RQ_AW-1:0]   r_rp;
    logic [RQ_CW-1:0]   r_count;
    logic               pop;
    logic [RQ_AW-1:0]   wp_next;
    logic [RQ_CW-1:0]   n_push;

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    // Room for a full pair of results, without counting this cycle's pop.
    assign o_room  = r_count <= RQ_CW'(RQ_DEPTH - 2);
    assign wp_next = r_wp + 1'b1;
    assign n_push  = RQ_CW'(i_push.valid0) + RQ_CW'(i_push.valid1);

    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.valid1) begin
            r_mem[wp_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + n_push[RQ_AW-1:0];
            r_rp    <= r_rp + RQ_AW'(pop);
            r_count <= r_count + n_push - RQ_CW'(pop);
        end
    end

    `DTA_NEVER(a_no_overflow, i_clk, i_rst_n, i_push.valid0 && !o_room)
    `DTA_NEVER(a_count_range, i_clk, i_rst_n, r_count > RQ_CW'(RQ_DEPTH))
    `DTA_ASSERT(a_stall_keeps, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid)

endmodule

`default_nettype wire

>>> design/display_timeout_adjust_controller_unit.sv
// Display timeout controller with two knobs: input register, per-item state update, result queue.
// An item's results pass through the input register and then the result queue before they can be taken.
// Throughput: one item per cycle while items give at most one result each and the
// output is not stalled; the four-entry result queue and its one-per-cycle read set this.
// Reset is synchronous and active low: timer cleared, display on, setup registers at defaults.
`default_nettype none

module display_timeout_adjust_controller_unit import dta_pkg::*; #(
    parameter logic [31:0] SAMPLE_MS       = SAMPLE_PERIOD_MS,
    parameter logic [31:0] SETTLE_LIMIT_MS = SETTLE_MS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [31:0]           i_now_ms,
    input  wire logic [15:0]           i_timeout_knob_pos,
    input  wire logic [15:0]           i_brightness_knob_pos,
    input  wire logic                  i_new_event,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [15:0]                o_report_value,
    output logic [2:0]                 o_report_kind,
    output logic                       o_last_of_run,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_item     r_in;
    logic      room;
    logic      fire;
    logic      accept;
    t_cfg_load cfg_load;
    logic      rep_en;
    t_push     push;
    t_result   head;

    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept || fire) begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.now_ms              <= i_now_ms;
            r_in.timeout_knob_pos    <= i_timeout_knob_pos;
            r_in.brightness_knob_pos <= i_brightness_knob_pos;
            r_in.new_event           <= i_new_event;
        end
    end

    dta_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_load     (cfg_load),
        .o_rep_en   (rep_en)
    );

    dta_core #(
        .SAMPLE_MS       (SAMPLE_MS),
        .SETTLE_LIMIT_MS (SETTLE_LIMIT_MS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_in),
        .i_cfg_load (cfg_load),
        .i_rep_en   (rep_en),
        .o_push     (push)
    );

    dta_rqueue u_rqueue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head)
    );

    assign o_report_value = head.report_value;
    assign o_report_kind  = head.report_kind;
    assign o_last_of_run  = head.last_of_run;

endmodule

`default_nettype wire
